>>> rtl/e2r_pkg.sv
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared constants, types and helpers for the Euler-to-DCM pipeline.
// ----------------------------------------------------------------------------
package e2r_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int FRACTION_BITS = 14;
  localparam int CORDIC_STAGES = 16;
  localparam int WORK_FRAC     = 30;

  // Q1.FRACTION_BITS value, one guard bit for +1.0 and one sign bit
  localparam int VW = FRACTION_BITS + 2;
  // Product of two VW values, plus growth for a three-term sum
  localparam int PW = 2 * VW + 2;
  // CORDIC datapath width: Q30 with headroom
  localparam int CW = 34;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(64'sd652032874);
  localparam logic signed [VW-1:0] ONE_Q       = VW'(64'sd1 << FRACTION_BITS);

  localparam int SEQ_COUNT = 12;
  localparam logic [3:0] SEQ_RESET = 4'd5;

  typedef logic signed [VW-1:0] val_t;
  typedef val_t [2:0][2:0] mat_t;
  typedef logic [1:0] axis_t;
  typedef axis_t [2:0] axes_t;

  // One accepted request as handed from the front part to the back part
  typedef struct packed {
    logic [ANGLE_BITS-1:0] ang0;
    logic [ANGLE_BITS-1:0] ang1;
    logic [ANGLE_BITS-1:0] ang2;
    axes_t                 axes;
    logic                  bad;
  } req_t;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] t [32];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
          32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
          32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
          32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
          32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
          32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
          32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
    return t[i % 32];
  endfunction

  // Axis list of each sequence code; x = 0, y = 1, z = 2
  function automatic axes_t seq_axes(input logic [3:0] code);
    axes_t a;
    case (code)
      4'd0:    a = '{2'd2, 2'd1, 2'd0};
      4'd1:    a = '{2'd1, 2'd2, 2'd0};
      4'd2:    a = '{2'd2, 2'd0, 2'd1};
      4'd3:    a = '{2'd0, 2'd2, 2'd1};
      4'd4:    a = '{2'd1, 2'd0, 2'd2};
      4'd5:    a = '{2'd0, 2'd1, 2'd2};
      4'd6:    a = '{2'd0, 2'd1, 2'd0};
      4'd7:    a = '{2'd0, 2'd2, 2'd0};
      4'd8:    a = '{2'd1, 2'd0, 2'd1};
      4'd9:    a = '{2'd1, 2'd2, 2'd1};
      4'd10:   a = '{2'd2, 2'd0, 2'd2};
      4'd11:   a = '{2'd2, 2'd1, 2'd2};
      default: a = '{2'd0, 2'd0, 2'd0};
    endcase
    return a;
  endfunction

  function automatic val_t sat_one(input logic signed [PW-1:0] v);
    val_t r;
    if (v > PW'(ONE_Q)) begin
      r = ONE_Q;
    end else if (v < -PW'(ONE_Q)) begin
      r = -ONE_Q;
    end else begin
      r = v[VW-1:0];
    end
    return r;
  endfunction

  // Elemental passive rotation about one axis
  function automatic mat_t elemental(input axis_t ax, input val_t c, input val_t s);
    mat_t r;
    axis_t j;
    axis_t k;
    j = (ax == 2'd2) ? 2'd0 : ax + 2'd1;
    k = (ax == 2'd0) ? 2'd2 : ax - 2'd1;
    r = '0;
    r[ax][ax] = ONE_Q;
    r[j][j]   = c;
    r[k][k]   = c;
    r[j][k]   = s;
    r[k][j]   = -s;
    return r;
  endfunction

endpackage

>>> rtl/e2r_front.sv
// ----------------------------------------------------------------------------
// e2r_front
// Takes input requests, attaches the decoded sequence and feeds the queue.
// ----------------------------------------------------------------------------
module e2r_front import e2r_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [3:0]            cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ANGLE_BITS-1:0] in_a0,
  input  logic [ANGLE_BITS-1:0] in_a1,
  input  logic [ANGLE_BITS-1:0] in_a2,
  output logic                  q_valid,
  input  logic                  q_ready,
  output req_t                  q_req
);

  localparam int QD = 2;

  logic [3:0] seq_r;
  req_t       q_mem_r [QD];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'(QD));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_req    = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SEQ_RESET;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        seq_r <= cfg_wr_data;
      end
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= '{ang0: in_a0, ang1: in_a1, ang2: in_a2,
                         axes: seq_axes(seq_r), bad: (seq_r >= 4'(SEQ_COUNT))};
    end
  end

endmodule

>>> rtl/e2r_cordic.sv
// ----------------------------------------------------------------------------
// e2r_cordic
// Pipelined rotation-mode CORDIC, one stage per register, with quadrant fold.
// ----------------------------------------------------------------------------
module e2r_cordic import e2r_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output val_t                  cos_o,
  output val_t                  sin_o
);

  logic signed [CW-1:0] x_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] z_r [CORDIC_STAGES+1];
  logic                 f_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] xo_r, yo_r;
  logic                 fo_r;
  logic [31:0]          ph;
  logic                 flip;

  assign ph   = 32'(angle) << (32 - ANGLE_BITS);
  assign flip = ph[31] ^ ph[30];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= CW'(signed'({ph[31] ^ flip, ph[30:0]}));
      f_r[0] <= flip;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam int SH = i % 32;
    logic signed [CW-1:0] dx, dy, a;
    assign dx = y_r[i] >>> SH;
    assign dy = x_r[i] >>> SH;
    assign a  = CW'(signed'({1'b0, atan_entry(i)}));
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - a;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + a;
        end
      end
    end
  end

  // Round to FRACTION_BITS and saturate
  localparam int RS = WORK_FRAC - FRACTION_BITS;
  logic signed [CW-1:0] xr, yr;
  assign xr = (x_r[CORDIC_STAGES] + CW'(64'sd1 << (RS - 1))) >>> RS;
  assign yr = (y_r[CORDIC_STAGES] + CW'(64'sd1 << (RS - 1))) >>> RS;

  always_ff @(posedge clk) begin
    if (en) begin
      xo_r <= CW'(signed'(sat_one(PW'(xr))));
      yo_r <= CW'(signed'(sat_one(PW'(yr))));
      fo_r <= f_r[CORDIC_STAGES];
    end
  end

  assign cos_o = fo_r ? -xo_r[VW-1:0] : xo_r[VW-1:0];
  assign sin_o = fo_r ? -yo_r[VW-1:0] : yo_r[VW-1:0];

endmodule

>>> rtl/e2r_back.sv
// ----------------------------------------------------------------------------
// e2r_back
// Three CORDICs, two registered 3x3 products, output result queue.
// ----------------------------------------------------------------------------
module e2r_back import e2r_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_valid,
  output logic   q_ready,
  input  req_t   q_req,
  output logic   out_valid,
  input  logic   out_ready,
  output mat_t   out_m,
  output logic   out_bad
);

  // Stages: CORDIC (S+2), elemental build (1), product1 mul (1), product1
  // sum (1), product2 mul (1), product2 sum (1)
  localparam int LAT = CORDIC_STAGES + 7;
  localparam int LW  = $clog2(LAT + 3);

  logic  en;
  logic  v_r [LAT];
  axes_t ax_r [LAT];
  logic  bad_r [LAT];
  logic [LW-1:0] fly_r;
  logic  acc;
  logic  outq_ready;

  // Credit: keep in-flight + buffered at most the skid depth
  localparam int BUFD = LAT + 2;
  mat_t  buf_m_r [BUFD];
  logic  buf_b_r [BUFD];
  logic [LW-1:0] wp_r, rp_r, bc_r;

  assign en      = 1'b1;
  assign q_ready = (fly_r + bc_r) < LW'(BUFD);
  assign acc     = q_valid && q_ready;

  val_t c0, s0, c1, s1, c2, s2;
  e2r_cordic u_c0 (.clk, .en, .angle(q_req.ang0), .cos_o(c0), .sin_o(s0));
  e2r_cordic u_c1 (.clk, .en, .angle(q_req.ang1), .cos_o(c1), .sin_o(s1));
  e2r_cordic u_c2 (.clk, .en, .angle(q_req.ang2), .cos_o(c2), .sin_o(s2));

  localparam int CL = CORDIC_STAGES + 2;
  always_ff @(posedge clk) begin
    ax_r[0]  <= q_req.axes;
    bad_r[0] <= q_req.bad;
    for (int i = 1; i < LAT; i++) begin
      ax_r[i]  <= ax_r[i-1];
      bad_r[i] <= bad_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= acc;
      for (int i = 1; i < LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  // Elemental matrices
  mat_t r1_r, r2_r, r3_r;
  always_ff @(posedge clk) begin
    r1_r <= elemental(ax_r[CL-1][0], c0, s0);
    r2_r <= elemental(ax_r[CL-1][1], c1, s1);
    r3_r <= elemental(ax_r[CL-1][2], c2, s2);
  end

  // T = round(R2 * R1)
  logic signed [PW-1:0] p1_r [3][3][3];
  mat_t r3d_r, t_r, r3e_r;
  always_ff @(posedge clk) begin
    r3d_r <= r3_r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++)
          p1_r[i][j][k] <= PW'(r2_r[i][k]) * PW'(r1_r[k][j]);
  end
  always_ff @(posedge clk) begin
    r3e_r <= r3d_r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        t_r[i][j] <= VW'((p1_r[i][j][0] + p1_r[i][j][1] + p1_r[i][j][2]
                        + PW'(64'sd1 << (FRACTION_BITS - 1))) >>> FRACTION_BITS);
  end

  // M = round(R3 * T), saturated
  logic signed [PW-1:0] p2_r [3][3][3];
  mat_t m_r;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++)
          p2_r[i][j][k] <= PW'(r3e_r[i][k]) * PW'(t_r[k][j]);
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m_r[i][j] <= sat_one((p2_r[i][j][0] + p2_r[i][j][1] + p2_r[i][j][2]
                     + PW'(64'sd1 << (FRACTION_BITS - 1))) >>> FRACTION_BITS);
  end

  // Result queue
  logic push, pop;
  assign push      = v_r[LAT-1];
  assign out_valid = (bc_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_m     = buf_b_r[rp_r] ? '0 : buf_m_r[rp_r];
  assign out_bad   = buf_b_r[rp_r];
  assign outq_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (push && outq_ready) begin
      buf_m_r[wp_r] <= m_r;
      buf_b_r[wp_r] <= bad_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      bc_r  <= '0;
      fly_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == LW'(BUFD - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == LW'(BUFD - 1)) ? '0 : rp_r + 1'b1;
      bc_r  <= bc_r + LW'(push) - LW'(pop);
      fly_r <= fly_r + LW'(acc) - LW'(push);
    end
  end

endmodule

>>> rtl/euler_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Euler angles to Q1.14 direction cosine matrix, twelve rotation sequences.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | tdata: angle_first, angle_second, angle_third
//  out_    | master    | tdata: m00..m22; tuser: bad_sequence
//  cfg_    | write     | rotation_sequence (4 bits, reset 5)
//
// One request per cycle sustained unless out_tready stalls fill the queue;
// depth set by the 16-stage CORDIC pipeline and two registered matrix products.
// Front part latches the sequence code with each request and queues it
// (2 entries); back part runs pipelined and drains into a result queue
// sized to its depth, so out_tready stalls never corrupt in-flight work.
// Reset (rst_n low, synchronous) empties all queues and loads sequence 5.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix import e2r_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [3:0]   cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // angle_first, angle_second, angle_third
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // m00,m01,m02,m10,m11,m12,m20,m21,m22
  output logic         out_tuser   // bad_sequence
);

  logic q_valid, q_ready;
  req_t q_req;
  mat_t m;

  e2r_front u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_a0(in_tdata[15:0]), .in_a1(in_tdata[31:16]), .in_a2(in_tdata[47:32]),
    .q_valid, .q_ready, .q_req
  );

  e2r_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_req,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_m(m), .out_bad(out_tuser)
  );

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      assign out_tdata[(i*3+j)*16 +: 16] = 16'(m[i][j]);
    end
  end

endmodule
